### design/gmmn_pkg.sv
`default_nettype none

package gmmn_pkg;

	// Default grid size; the top level hands these down as parameters.
	localparam int DEF_GRID_WIDTH  = 64;
	localparam int DEF_GRID_HEIGHT = 64;

	localparam int IDX_W    = 6;
	localparam int SAMPLE_W = 16;
	localparam int NORM_W   = 16;
	localparam int PROD_W   = 2 * NORM_W;

	// Scale factors are 2**shift - 1, so the product is a shift and a subtract.
	localparam int UNIT_SHIFT  = 16;
	localparam int PIXEL_SHIFT = 8;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic MODE_UNIT  = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic [IDX_W-1:0]           col;
		logic [IDX_W-1:0]           row;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [NORM_W-1:0] norm_value;
		logic              flat;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [NORM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [NORM_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

### design/grid_min_max_normalizer.sv
// Grid min-max normalizer.
// The input channel (in_valid, in_stall, in_data) carries commands: clear,
// write a cell, or read a cell normalized as (v - min) / (max - min).
// Only a read produces a transfer on the output channel (out_valid, out_stall,
// out_data); clears, writes and unused commands produce none.
// The one configuration register mode_q is written through cfg_we and
// cfg_wdata: 0 scales to 65535, 1 scales to 255. The user must write it only
// while the block is idle; the block itself does not enforce this.
// Clears and writes leave the controller idle. A read whose cell lies in the
// grid on a grid that is not flat passes through the clamp, scale and divide
// states, the last waiting on the radix-2 divider, before the push state, and
// no new command is taken until its result has entered the output register.
// Reads outside the grid or on a flat grid go straight to the push state.
// The result sits in an output register, so a new command is taken while an
// earlier result still waits; a read whose result finds that register full
// and stalled holds off further commands until the register drains.
// Reset clears the running minimum, maximum and the seen flag, sets mode_q
// to 0 and empties the output register. The cell memory is not cleared:
// a cell must be written before it is read.
`default_nettype none

module grid_min_max_normalizer #(
	parameter int GRID_WIDTH  = gmmn_pkg::DEF_GRID_WIDTH,
	parameter int GRID_HEIGHT = gmmn_pkg::DEF_GRID_HEIGHT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire gmmn_pkg::in_item_t  in_data,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      gmmn_pkg::out_item_t out_data,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata
);
	import gmmn_pkg::*;

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLAMP,
		S_SCALE,
		S_DIV,
		S_PUSH
	} state_t;

	state_t                     state_q;
	logic                       out_valid_q;
	logic                       seen_q;
	logic                       mode_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] max_q;
	out_item_t                  res_q;
	out_item_t                  out_q;
	logic [NORM_W-1:0]          diff_q;
	logic [NORM_W-1:0]          span_q;

	logic                       accept;
	logic                       in_range;
	logic                       is_flat;
	logic                       out_load;
	logic [AW-1:0]              addr;
	logic                       mem_we;
	logic                       mem_re;
	logic [SAMPLE_W-1:0]        mem_rdata;
	logic signed [SAMPLE_W-1:0] rd_v;
	logic signed [SAMPLE_W-1:0] clamp_v;
	logic signed [SAMPLE_W:0]   diff_wide;
	logic signed [SAMPLE_W:0]   span_wide;
	logic [PROD_W-1:0]          scaled;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	// Commands are taken only while the controller is idle.
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	assign in_range = (32'(in_data.col) < 32'(GRID_WIDTH)) &&
	                  (32'(in_data.row) < 32'(GRID_HEIGHT));
	assign addr     = AW'(32'(in_data.row) * 32'(GRID_WIDTH) + 32'(in_data.col));
	assign mem_we   = accept && (in_data.cmd == CMD_WRITE) && in_range;
	assign mem_re   = accept && (in_data.cmd == CMD_READ) && in_range;

	// With nothing written since the last clear the grid counts as flat.
	assign is_flat  = !seen_q || (max_q <= min_q);

	// The pending result moves into the output register once it is free.
	assign out_load = (state_q == S_PUSH) && (!out_valid_q || !out_stall);

	gmmn_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (addr),
		.wdata(in_data.sample),
		.rdata(mem_rdata)
	);

	// A stale cell may lie outside the current range, so clamp it first.
	assign rd_v      = signed'(mem_rdata);
	assign clamp_v   = (rd_v < min_q) ? min_q : ((rd_v > max_q) ? max_q : rd_v);
	assign diff_wide = (SAMPLE_W + 1)'(clamp_v) - (SAMPLE_W + 1)'(min_q);
	assign span_wide = (SAMPLE_W + 1)'(max_q) - (SAMPLE_W + 1)'(min_q);

	// diff * (2**k - 1) as a shift and one subtract.
	always_comb begin
		case (mode_q)
			MODE_PIXEL: scaled = (PROD_W'(diff_q) << PIXEL_SHIFT) - PROD_W'(diff_q);
			default:    scaled = (PROD_W'(diff_q) << UNIT_SHIFT) - PROD_W'(diff_q);
		endcase
	end

	assign div_req.start    = (state_q == S_SCALE);
	assign div_req.dividend = scaled;
	assign div_req.divisor  = span_q;

	gmmn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			seen_q      <= 1'b0;
			mode_q      <= MODE_UNIT;
			min_q       <= '0;
			max_q       <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (in_data.cmd)
							CMD_CLEAR: begin
								seen_q <= 1'b0;
								min_q  <= '0;
								max_q  <= '0;
							end
							CMD_WRITE: begin
								if (in_range) begin
									seen_q <= 1'b1;
									if (!seen_q || (in_data.sample < min_q)) begin
										min_q <= in_data.sample;
									end
									if (!seen_q || (in_data.sample > max_q)) begin
										max_q <= in_data.sample;
									end
								end
							end
							CMD_READ: begin
								state_q <= (in_range && !is_flat) ? S_CLAMP : S_PUSH;
							end
							default: begin
							end
						endcase
					end
				end
				S_CLAMP: state_q <= S_SCALE;
				S_SCALE: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload. A read outside the grid answers 0 with flat clear; a
	// read on a flat grid answers 0 with flat set.
	always_ff @(posedge clk) begin
		if (accept && (in_data.cmd == CMD_READ)) begin
			res_q.norm_value <= '0;
			res_q.flat       <= in_range;
		end
		if (state_q == S_CLAMP) begin
			diff_q <= diff_wide[NORM_W-1:0];
			span_q <= span_wide[NORM_W-1:0];
		end
		if ((state_q == S_DIV) && div_rsp.done) begin
			res_q.norm_value <= div_rsp.quotient;
			res_q.flat       <= 1'b0;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> ((min_q == '0) && (max_q == '0)))
		else $error("range not zero while no sample seen");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (min_q <= max_q))
		else $error("running minimum above running maximum");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_PUSH) && out_valid_q && out_stall) |=> (state_q == S_PUSH))
		else $error("pending result dropped while output was stalled");

endmodule

`default_nettype wire

### design/gmmn_mem.sv
`default_nettype none

module gmmn_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic                            re,
	input  wire logic [AW-1:0]                   addr,
	input  wire logic [gmmn_pkg::SAMPLE_W-1:0]   wdata,
	output      logic [gmmn_pkg::SAMPLE_W-1:0]   rdata
);
	import gmmn_pkg::*;

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;

	// Single port: the controller never writes and reads in the same cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### design/gmmn_div.sv
`default_nettype none

module gmmn_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire gmmn_pkg::div_req_t req,
	output      gmmn_pkg::div_rsp_t rsp
);
	import gmmn_pkg::*;

	localparam int CNT_W = $clog2(NORM_W);

	logic [NORM_W-1:0] rem_q;
	logic [NORM_W-1:0] quo_q;
	logic [NORM_W-1:0] divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [NORM_W:0]   shifted;
	logic [NORM_W+1:0] trial;
	logic              fits;

	// Restoring division, one quotient bit per cycle. The low dividend bits
	// shift out of quo_q while quotient bits shift in at the bottom.
	assign shifted = {rem_q, quo_q[NORM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};
	assign fits    = ~trial[NORM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NORM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.dividend[PROD_W-1:NORM_W];
			quo_q     <= req.dividend[NORM_W-1:0];
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[NORM_W-1:0] : shifted[NORM_W-1:0];
			quo_q <= {quo_q[NORM_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < divisor_q))
		else $error("partial remainder reached the divisor");

endmodule

`default_nettype wire
